[rtl/kwlex_pkg.sv]
// types and constants shared by the keyword token lexer
package kwlex_pkg;

    localparam int TOKEN_TEXT_W = 64;
    localparam int TOKEN_LEN_W  = 8;

    typedef enum logic [2:0] {
        KIND_KEYWORD = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_OPER    = 3'd3,
        KIND_BRACKET = 3'd4,
        KIND_UNKNOWN = 3'd5,
        KIND_END     = 3'd6
    } token_kind_t;

    typedef enum logic [2:0] {
        RUN_NONE   = 3'b001,
        RUN_IDENT  = 3'b010,
        RUN_NUMBER = 3'b100
    } run_kind_t;

    typedef struct packed {
        token_kind_t              kind;
        logic [TOKEN_LEN_W-1:0]   length;
        logic [TOKEN_TEXT_W-1:0]  text;
        logic                     last;
    } token_t;

    localparam logic [TOKEN_TEXT_W-1:0] KW_IF   = 64'h0000_0000_0000_6669;
    localparam logic [TOKEN_TEXT_W-1:0] KW_DEF  = 64'h0000_0000_0066_6564;
    localparam logic [TOKEN_TEXT_W-1:0] KW_LET  = 64'h0000_0000_0074_656C;
    localparam logic [TOKEN_TEXT_W-1:0] KW_THEN = 64'h0000_0000_6E65_6874;
    localparam logic [TOKEN_TEXT_W-1:0] KW_ELSE = 64'h0000_0000_6573_6C65;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_keyword(input logic [TOKEN_LEN_W-1:0] len,
                                        input logic [TOKEN_TEXT_W-1:0] text);
        return (len == 8'd2 && text == KW_IF) ||
               (len == 8'd3 && (text == KW_DEF || text == KW_LET)) ||
               (len == 8'd4 && (text == KW_THEN || text == KW_ELSE));
    endfunction

endpackage

[rtl/keyword_token_lexer_top.sv]
// keyword token lexer: one text byte per request in, tokens out
// Takes one text byte per cycle while the result side is ready and queues its tokens. A byte
// passes an input register, is classified against the open run combinationally, and its
// tokens land in a two-entry result queue whose head drives the outputs. A byte that closes
// a run and also forms a token of its own (or an end mark after an open run) gives two tokens
// and needs two free queue slots; while the queue still holds an earlier surplus token, such
// a byte waits until the queue drains a token. A byte that gives no token (a run byte or
// whitespace) lets the queue absorb a surplus token. Other bytes sustain one per cycle while
// tokens are taken. Runs keep their first TEXT_BYTES bytes; lengths saturate at 255.
module keyword_token_lexer_top #(
    parameter int TEXT_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic [0:0]  s_tuser,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // token_length [7:0], token_text [71:8]
    output logic [2:0]  m_tuser,   // token_kind
    output logic        m_tlast    // last_of_run
);
    import kwlex_pkg::*;

    localparam int TextW = TEXT_BYTES * 8;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_eot_reg;

    run_kind_t        run_kind_reg, run_kind_next;
    logic [7:0]       run_len_reg, run_len_next;
    logic [TextW-1:0] run_text_reg, run_text_next;

    token_t           q_reg [2];
    token_t           q_next [2];
    logic [1:0]       cnt_reg, cnt_next, cnt_after, free, n_res;

    logic             s_accept, pop, fire;
    logic             letter, digit, space, has_run, extend, emit_run, other_valid;
    logic [7:0]       app_len;
    logic [TextW-1:0] app_text;
    token_t           run_tok, other_tok, tok0, tok1;

    assign s_accept = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    assign letter  = is_letter(in_byte_reg);
    assign digit   = is_digit(in_byte_reg);
    assign space   = is_space(in_byte_reg);
    assign has_run = (run_kind_reg == RUN_IDENT) || (run_kind_reg == RUN_NUMBER);
    assign extend  = !in_eot_reg &&
                     ((run_kind_reg == RUN_IDENT && (letter || digit)) ||
                      (run_kind_reg == RUN_NUMBER && digit));

    assign emit_run    = has_run && !extend;
    assign other_valid = in_eot_reg || (!extend && !space && !letter && !digit);
    assign n_res       = 2'({1'b0, emit_run}) + 2'({1'b0, other_valid});

    assign free     = 2'd2 - cnt_reg + 2'({1'b0, pop});
    assign fire     = in_valid_reg && (n_res <= free);
    assign s_tready = !in_valid_reg || fire;

    assign app_len = (run_len_reg == 8'hFF) ? run_len_reg : run_len_reg + 8'd1;

    always_comb begin
        app_text = run_text_reg;
        for (int i = 0; i < TEXT_BYTES; i++) begin
            if (run_len_reg == 8'(i)) begin
                app_text[i*8 +: 8] = in_byte_reg;
            end
        end
    end

    always_comb begin
        run_tok.length = run_len_reg;
        run_tok.text   = TOKEN_TEXT_W'(run_text_reg);
        run_tok.last   = !other_valid;
        if (run_kind_reg == RUN_IDENT) begin
            run_tok.kind = is_keyword(run_len_reg, TOKEN_TEXT_W'(run_text_reg)) ?
                           KIND_KEYWORD : KIND_IDENT;
        end else begin
            run_tok.kind = KIND_NUMBER;
        end

        other_tok.length = 8'd1;
        other_tok.text   = TOKEN_TEXT_W'(in_byte_reg);
        other_tok.last   = 1'b1;
        priority if (in_eot_reg) begin
            other_tok.kind   = KIND_END;
            other_tok.length = 8'd0;
            other_tok.text   = '0;
        end else if (in_byte_reg == CH_PLUS || in_byte_reg == CH_MINUS ||
                     in_byte_reg == CH_STAR || in_byte_reg == CH_SLASH ||
                     in_byte_reg == CH_EQUAL) begin
            other_tok.kind = KIND_OPER;
        end else if (in_byte_reg == CH_LPAREN || in_byte_reg == CH_RPAREN ||
                     in_byte_reg == CH_LBRACE || in_byte_reg == CH_RBRACE) begin
            other_tok.kind = KIND_BRACKET;
        end else begin
            other_tok.kind = KIND_UNKNOWN;
        end

        tok0 = emit_run ? run_tok : other_tok;
        tok1 = other_tok;
    end

    // run state update
    always_comb begin
        run_kind_next = run_kind_reg;
        run_len_next  = run_len_reg;
        run_text_next = run_text_reg;
        if (fire) begin
            priority if (in_eot_reg) begin
                run_kind_next = RUN_NONE;
                run_len_next  = 8'd0;
                run_text_next = '0;
            end else if (extend) begin
                run_len_next  = app_len;
                run_text_next = app_text;
            end else if (letter || digit) begin
                run_kind_next = letter ? RUN_IDENT : RUN_NUMBER;
                run_len_next  = 8'd1;
                run_text_next = TextW'(in_byte_reg);
            end else begin
                run_kind_next = RUN_NONE;
                run_len_next  = 8'd0;
                run_text_next = '0;
            end
        end
    end

    // result queue: head in slot 0
    always_comb begin
        q_next    = q_reg;
        cnt_after = cnt_reg - 2'({1'b0, pop});
        if (pop) begin
            q_next[0] = q_reg[1];
        end
        if (fire) begin
            unique case (n_res)
                2'd1: q_next[cnt_after[0]] = tok0;
                2'd2: begin
                    q_next[0] = tok0;
                    q_next[1] = tok1;
                end
                default: ;
            endcase
        end
        cnt_next = cnt_after + (fire ? n_res : 2'd0);
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
            run_kind_reg <= RUN_NONE;
            run_len_reg  <= 8'd0;
            run_text_reg <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            run_kind_reg <= run_kind_next;
            run_len_reg  <= run_len_next;
            run_text_reg <= run_text_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tuser[0];
        end
        q_reg <= q_next;
    end

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = {q_reg[0].text, q_reg[0].length};
    assign m_tuser  = q_reg[0].kind;
    assign m_tlast  = q_reg[0].last;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_eot_clears_run: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_eot_reg |=> run_kind_reg == RUN_NONE && run_len_reg == 8'd0)
        else $error("run still open after end of text");

    a_open_run_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        run_kind_reg != RUN_NONE |-> run_len_reg != 8'd0)
        else $error("open run with zero length");

    a_end_token_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && q_reg[0].kind == KIND_END |-> q_reg[0].last && q_reg[0].length == 8'd0)
        else $error("end token not marked last or has a length");

endmodule

[tb/sv/keyword_token_lexer_top_tb.sv]
// self-checking testbench for the keyword token lexer: directed, long-run, stall and random text
module keyword_token_lexer_top_tb;
    import kwlex_pkg::*;

    localparam int RUN_BYTES   = 8;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [1:0] {
        OPEN_NONE   = 2'd0,
        OPEN_WORD   = 2'd1,
        OPEN_DIGITS = 2'd2
    } open_run_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // lexer state as predicted
    open_run_t        open_run  = OPEN_NONE;
    logic [7:0]       open_len  = 8'd0;
    logic [63:0]      open_text = 64'd0;
    token_t           pending_tokens[$];

    bit src_gaps  = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_req  = 1'b0;

    int errors         = 0;
    int offered_n      = 0;
    int accepted_n     = 0;
    int end_marks      = 0;
    int tokens_checked = 0;
    int longest_run    = 0;

    string kw_list[5] = '{"def", "let", "if", "then", "else"};

    keyword_token_lexer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic bit alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit blank(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void push_token(input token_kind_t kind, input logic [7:0] len,
                                       input logic [63:0] text);
        token_t t;
        t.kind   = kind;
        t.length = len;
        t.text   = text;
        t.last   = 1'b0;
        pending_tokens.insert(pending_tokens.size(), t);
    endfunction

    function automatic void grow_run(input logic [7:0] b);
        if (open_len < RUN_BYTES)
            open_text[8*open_len +: 8] = b;
        if (open_len != 8'd255)
            open_len = open_len + 8'd1;
        if (open_len > longest_run)
            longest_run = int'(open_len);
    endfunction

    function automatic void emit_open_run();
        bit kw;
        kw = (open_len == 8'd2 && open_text == KW_IF) ||
             (open_len == 8'd3 && (open_text == KW_DEF || open_text == KW_LET)) ||
             (open_len == 8'd4 && (open_text == KW_THEN || open_text == KW_ELSE));
        if (open_run == OPEN_WORD)
            push_token(kw ? KIND_KEYWORD : KIND_IDENT, open_len, open_text);
        else if (open_run == OPEN_DIGITS)
            push_token(KIND_NUMBER, open_len, open_text);
        open_run  = OPEN_NONE;
        open_len  = 8'd0;
        open_text = 64'd0;
    endfunction

    function automatic void lex_step(input logic [7:0] b, input logic eot);
        int n_prior;
        n_prior = pending_tokens.size();
        accepted_n++;
        if (eot) begin
            end_marks++;
            emit_open_run();
            push_token(KIND_END, 8'd0, 64'd0);
        end else if (open_run == OPEN_WORD && (alpha(b) || numeral(b))) begin
            grow_run(b);
        end else if (open_run == OPEN_DIGITS && numeral(b)) begin
            grow_run(b);
        end else begin
            emit_open_run();
            if (blank(b)) begin
            end else if (alpha(b)) begin
                open_run = OPEN_WORD;
                grow_run(b);
            end else if (numeral(b)) begin
                open_run = OPEN_DIGITS;
                grow_run(b);
            end else if (b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH ||
                         b == CH_EQUAL) begin
                push_token(KIND_OPER, 8'd1, {56'd0, b});
            end else if (b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE ||
                         b == CH_RBRACE) begin
                push_token(KIND_BRACKET, 8'd1, {56'd0, b});
            end else begin
                push_token(KIND_UNKNOWN, 8'd1, {56'd0, b});
            end
        end
        if (pending_tokens.size() > n_prior)
            pending_tokens[pending_tokens.size()-1].last = 1'b1;
    endfunction

    function automatic void check_token();
        token_t want;
        if (pending_tokens.size() == 0) begin
            errors++;
            $display("%0t unexpected token: expected none, actual kind %0d len %0d text %h",
                     $time, m_tuser, m_tdata[7:0], m_tdata[71:8]);
            return;
        end
        want = pending_tokens.pop_front();
        tokens_checked++;
        if (m_tuser !== want.kind) begin
            errors++;
            $display("%0t token_kind: expected %0d, actual %0d", $time, want.kind, m_tuser);
        end
        if (m_tdata[7:0] !== want.length) begin
            errors++;
            $display("%0t token_length: expected %0d, actual %0d", $time, want.length,
                     m_tdata[7:0]);
        end
        if (m_tdata[71:8] !== want.text) begin
            errors++;
            $display("%0t token_text: expected %h, actual %h", $time, want.text, m_tdata[71:8]);
        end
        if (m_tlast !== want.last) begin
            errors++;
            $display("%0t last_of_run: expected %0d, actual %0d", $time, want.last, m_tlast);
        end
    endfunction

    // prediction first so a request and its tokens never race
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                lex_step(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready)
                check_token();
        end
    end

    // result side readiness, with one long hold-off on request
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!sink_gaps || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
    end

    task automatic send_req(input logic [7:0] b, input logic eot);
        if (src_gaps && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eot;
        offered_n++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_req(s[i], 1'b0);
    endtask

    task automatic send_eot();
        send_req(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_tokens.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                    : 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    function automatic logic [7:0] rand_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : 8'(8'h09 + k);
    endfunction

    // one well-formed lexeme most of the time, noise or an end mark otherwise
    task automatic send_lexeme();
        int pick;
        int n;
        logic [7:0] b;
        logic [7:0] ops[5];
        logic [7:0] brk[4];
        ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL};
        brk = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE};
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            send_text(kw_list[$urandom_range(0, 4)]);
            if ($urandom_range(0, 3) == 0)
                send_req($urandom_range(0, 1) ? rand_letter() : rand_digit(), 1'b0);
        end else if (pick < 35) begin
            n = $urandom_range(1, 11);
            send_req(rand_letter(), 1'b0);
            for (int i = 1; i < n; i++)
                send_req($urandom_range(0, 2) ? rand_letter() : rand_digit(), 1'b0);
        end else if (pick < 50) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                send_req(rand_digit(), 1'b0);
        end else if (pick < 60) begin
            send_req(ops[$urandom_range(0, 4)], 1'b0);
        end else if (pick < 68) begin
            send_req(brk[$urandom_range(0, 3)], 1'b0);
        end else if (pick < 78) begin
            send_req(rand_blank(), 1'b0);
        end else if (pick < 84) begin
            do b = 8'($urandom_range(0, 255));
            while (alpha(b) || numeral(b) || blank(b));
            send_req(b, 1'b0);
        end else if (pick < 95) begin
            send_req(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_eot();
        end
        if (pick < 50 && $urandom_range(0, 4) < 3)
            send_req(rand_blank(), 1'b0);
    endtask

    task automatic test_directed();
        send_text("if(7z2");
        send_req(CH_TAB, 1'b0);
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(8'h80, 1'b0);
        send_text("+-*/=){}");
        send_text("x");
        send_eot();
        send_eot();
        send_text("5");
        send_req(CH_CR, 1'b0);
        send_req(8'hFF, 1'b1);
    endtask

    task automatic test_long_runs();
        send_text("abcdefgh abcdefghi 12345678 123456789 ");
        send_req("Q", 1'b0);
        for (int i = 0; i < 259; i++)
            send_req($urandom_range(0, 3) ? rand_letter() : rand_digit(), 1'b0);
        send_req(CH_SPACE, 1'b0);
        for (int i = 0; i < 256; i++)
            send_req(rand_digit(), 1'b0);
        send_eot();
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_req = 1'b1;
        src_gaps = 1'b0;
        for (int i = 0; i < 40; i++)
            send_req($urandom_range(0, 1) ? CH_PLUS : rand_letter(), 1'b0);
        send_text("a(b)c=def{1}");
        src_gaps = 1'b1;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_lexeme();
        wait_drained();
        send_text("then else");
        send_eot();
    endtask

    task automatic test_random();
        int stop_at;
        stop_at = offered_n + 260;
        while (offered_n < stop_at) begin
            src_gaps  = $urandom_range(0, 3) != 0;
            sink_gaps = $urandom_range(0, 3) != 0;
            for (int i = 0; i < 25; i++)
                send_lexeme();
        end
    endtask

    task automatic test_steady();
        int stop_at;
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        stop_at = offered_n + 100;
        while (offered_n < stop_at)
            send_lexeme();
        send_text("let x1=42 ");
        send_eot();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_long_runs();
        test_backpressure();
        test_drain_pause();
        test_random();
        test_steady();
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("lexed %0d requests (%0d end marks) into %0d checked tokens",
                 accepted_n, end_marks, tokens_checked);
        $display("longest run %0d bytes, one output hold-off of %0d cycles, %0d mismatches",
                 longest_run, HOLD_CYCLES, errors);
        if (errors == 0 && pending_tokens.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/kwlex_pkg.sv
rtl/keyword_token_lexer_top.sv
tb/sv/keyword_token_lexer_top_tb.sv
